FILE: rtl/swq_pkg.sv
// Package for the sorted wake-up queue.
// Holds the request and response beat types, the opcodes and the cell control group.
// Depends on nothing.
package swq_pkg;

	localparam logic OP_INSERT = 1'b0;
	localparam logic OP_CHECK  = 1'b1;

	localparam int TIME_W = 32;
	localparam int TASK_W = 8;

	typedef struct packed {
		logic              opcode;
		logic [TIME_W-1:0] wake_time;
		logic [TASK_W-1:0] task_id;
		logic [TIME_W-1:0] current_time;
	} req_t;

	typedef struct packed {
		logic              woke;
		logic [TASK_W-1:0] woken_task;
		logic              lost;
	} rsp_t;

	// Broadcast to every cell of the row in the cycle a request beat is taken.
	typedef struct packed {
		logic ins;
		logic pop;
	} cell_ctl_t;

endpackage

FILE: rtl/sorted_wakeup_queue.sv
// Sorted wake-up queue: top level, a row of swq_cell slots and the response register.
// Depends on swq_pkg and swq_cell.
//
// The queue keeps QUEUE_DEPTH wake-up requests in a row of cells, active entries first and
// sorted by wake time, older entries ahead of younger ones with the same time. An insert
// beat (opcode 0) lands behind every entry with an equal or earlier time and pushes the
// later entries back by one; when the queue is full the last entry falls off, or, if no
// entry is later than the new time, the new request is dropped, and either way lost is
// set. A check beat (opcode 1) compares current_time with the head: if the head is active
// and due it is popped, every entry moves forward, and woke is set with the task id. Every
// request beat gives exactly one response beat. Each cell compares its own time with the
// new request in parallel, so the block takes one request per clock; a request is held
// off only while a finished response sits in the output register and the consumer
// stalls it. Marking the task runnable is up to the consumer. Task ids are kept to
// TASK_BITS bits.
module sorted_wakeup_queue #(
	parameter int QUEUE_DEPTH = 8,
	parameter int TASK_BITS   = 8
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          req_valid,
	output logic          req_stall,
	input  swq_pkg::req_t req,
	output logic          rsp_valid,
	input  logic          rsp_stall,
	output swq_pkg::rsp_t rsp
);
	import swq_pkg::*;

	// Row of slots, one entry per cell, each also read by its neighbouring cells.
	logic [TIME_W-1:0]    slot_time   [QUEUE_DEPTH];
	logic [TASK_BITS-1:0] slot_task   [QUEUE_DEPTH];
	logic [QUEUE_DEPTH-1:0] slot_active;
	logic [QUEUE_DEPTH-1:0] slot_after;

	logic                 take;
	logic                 head_due;
	logic [TASK_BITS-1:0] new_task;
	cell_ctl_t            ctl;

	rsp_t rsp_d;
	rsp_t rsp_q;
	logic rsp_valid_q;

	// Hold the request side only while a response waits and the consumer stalls.
	assign req_stall = rsp_valid_q && rsp_stall;
	assign take      = req_valid && !req_stall;

	// Mask the task id to the stored width.
	assign new_task = TASK_BITS'(req.task_id);

	assign head_due = slot_active[0] && (req.current_time >= slot_time[0]);

	assign ctl.ins = take && (req.opcode == OP_INSERT);
	assign ctl.pop = take && (req.opcode == OP_CHECK) && head_due;

	genvar k;
	generate
		for (k = 0; k < QUEUE_DEPTH; k++) begin : g_cell
			logic                 p_after;
			logic [TIME_W-1:0]    p_time;
			logic [TASK_BITS-1:0] p_task;
			logic                 p_active;
			logic [TIME_W-1:0]    n_time;
			logic [TASK_BITS-1:0] n_task;
			logic                 n_active;

			if (k == 0) begin : g_head
				// Nothing ahead of the head: a request that does not go behind it goes here.
				assign p_after  = 1'b1;
				assign p_time   = '0;
				assign p_task   = '0;
				assign p_active = 1'b0;
			end else begin : g_body
				assign p_after  = slot_after[k-1];
				assign p_time   = slot_time[k-1];
				assign p_task   = slot_task[k-1];
				assign p_active = slot_active[k-1];
			end

			if (k == QUEUE_DEPTH - 1) begin : g_tail
				// Pop shifts an empty slot into the tail.
				assign n_time   = '0;
				assign n_task   = '0;
				assign n_active = 1'b0;
			end else begin : g_mid
				assign n_time   = slot_time[k+1];
				assign n_task   = slot_task[k+1];
				assign n_active = slot_active[k+1];
			end

			swq_cell #(
				.TASK_BITS(TASK_BITS)
			) u_cell (
				.clk        (clk),
				.arst_n     (arst_n),
				.ctl        (ctl),
				.new_time   (req.wake_time),
				.new_task   (new_task),
				.prev_after (p_after),
				.prev_time  (p_time),
				.prev_task  (p_task),
				.prev_active(p_active),
				.next_time  (n_time),
				.next_task  (n_task),
				.next_active(n_active),
				.slot_time  (slot_time[k]),
				.slot_task  (slot_task[k]),
				.slot_active(slot_active[k]),
				.after      (slot_after[k])
			);
		end
	endgenerate

	// Build the response. Active slots are packed at the front, so a full queue always
	// loses a request on insert: the tail, or the new one when it belongs past the tail.
	always_comb begin
		rsp_d = '0;
		if (req.opcode == OP_INSERT) begin
			rsp_d.lost = slot_active[QUEUE_DEPTH-1];
		end else if (head_due) begin
			rsp_d.woke       = 1'b1;
			rsp_d.woken_task = TASK_W'(slot_task[0]);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (take) begin
			rsp_valid_q <= 1'b1;
		end else if (!rsp_stall) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			rsp_q <= rsp_d;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

`ifndef SYNTHESIS
	// Active slots always form one run from the head.
	a_active_packed: assert property (@(posedge clk) disable iff (!arst_n)
		(slot_active & (slot_active + QUEUE_DEPTH'(1))) == '0)
		else $error("active slots not packed at the head");

	// Every taken request gives a response in the next cycle.
	a_rsp_follows: assert property (@(posedge clk) disable iff (!arst_n)
		take |=> rsp_valid)
		else $error("request taken without a response");

	// A response never both wakes and loses.
	a_woke_lost: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> !(rsp.woke && rsp.lost))
		else $error("response both woke and lost");

	// No task id without a wake.
	a_task_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && !rsp.woke) |-> (rsp.woken_task == '0))
		else $error("woken_task set without woke");

	// A pop leaves the head holding what the second slot held.
	a_pop_shift: assert property (@(posedge clk) disable iff (!arst_n)
		(ctl.pop && slot_active[1]) |=> (slot_time[0] == $past(slot_time[1])))
		else $error("pop did not advance the queue");
`endif

endmodule

FILE: rtl/swq_cell.sv
// One slot of the sorted wake-up queue: time, task and active flag.
// Compares its own time with the new request and loads from itself, its neighbours or the
// new request. Depends on swq_pkg.
module swq_cell #(
	parameter int TASK_BITS = 8
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  swq_pkg::cell_ctl_t         ctl,
	input  logic [swq_pkg::TIME_W-1:0] new_time,
	input  logic [TASK_BITS-1:0]       new_task,
	input  logic                       prev_after,
	input  logic [swq_pkg::TIME_W-1:0] prev_time,
	input  logic [TASK_BITS-1:0]       prev_task,
	input  logic                       prev_active,
	input  logic [swq_pkg::TIME_W-1:0] next_time,
	input  logic [TASK_BITS-1:0]       next_task,
	input  logic                       next_active,
	output logic [swq_pkg::TIME_W-1:0] slot_time,
	output logic [TASK_BITS-1:0]       slot_task,
	output logic                       slot_active,
	output logic                       after
);
	import swq_pkg::*;

	logic [TIME_W-1:0]    time_q;
	logic [TASK_BITS-1:0] task_q;
	logic                 active_q;

	// New request goes behind this slot when the slot holds an equal or earlier time.
	assign after = active_q && (time_q <= new_time);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= 1'b0;
		end else if (ctl.pop) begin
			active_q <= next_active;
		end else if (ctl.ins && !after) begin
			active_q <= prev_after ? 1'b1 : prev_active;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.pop) begin
			time_q <= next_time;
			task_q <= next_task;
		end else if (ctl.ins && !after) begin
			if (prev_after) begin
				time_q <= new_time;
				task_q <= new_task;
			end else begin
				time_q <= prev_time;
				task_q <= prev_task;
			end
		end
	end

	assign slot_time   = time_q;
	assign slot_task   = task_q;
	assign slot_active = active_q;

endmodule

FILE: test/sorted_wakeup_queue_tb.sv
`timescale 1ns / 100ps
// Self-checking bench for sorted_wakeup_queue: insert and check beats under random gaps and
// stalls, each response compared with a bench-side model of the sorted slot row.
// Depends on swq_pkg and the sorted_wakeup_queue RTL.
module sorted_wakeup_queue_tb;
	import swq_pkg::*;

	localparam int DEPTH       = 8;
	localparam int TBITS       = 8;
	localparam int QUIET_LIMIT = 1000;	// cycles with no beat on either side before giving up
	localparam int MAX_SHOWN   = 10;
	localparam logic [TASK_W-1:0] TASK_MASK = TASK_W'((1 << TBITS) - 1);

	// Every input has a known value from time zero; reset is held low from the start.
	logic clk       = 1'b0;
	logic arst_n    = 1'b0;
	logic req_valid = 1'b0;
	logic req_stall;
	req_t req       = '0;
	logic rsp_valid;
	logic rsp_stall = 1'b0;
	rsp_t rsp;

	sorted_wakeup_queue #(
		.QUEUE_DEPTH(DEPTH),
		.TASK_BITS  (TBITS)
	) u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.req_valid(req_valid),
		.req_stall(req_stall),
		.req      (req),
		.rsp_valid(rsp_valid),
		.rsp_stall(rsp_stall),
		.rsp      (rsp)
	);

	always #5 clk = ~clk;

	// Bench copy of the slot row: live entries at the front, sorted by wake time,
	// older entries ahead of younger ones with the same time.
	logic [TIME_W-1:0] row_time [DEPTH] = '{default: '0};
	logic [TASK_W-1:0] row_task [DEPTH] = '{default: '0};
	logic              row_live [DEPTH] = '{default: 1'b0};

	rsp_t awaited_rsp [$];	// responses still owed by the block, oldest first
	int   mismatches   = 0;
	int   quiet_cycles = 0;
	int   rsp_hold     = 0;	// stall cycles still to apply before the next response beat
	bit   idle_en      = 1'b1;	// when clear, neither side idles or stalls

	// Apply one accepted request beat to the slot row and return the response it earns.
	function automatic rsp_t next_wakeup_rsp(req_t r);
		rsp_t o;
		int   pos;
		int   k;
		o = '0;
		if (r.opcode == OP_INSERT) begin
			// Find the first slot that is empty or holds a strictly later time.
			pos = 0;
			while (pos < DEPTH && row_live[pos] && row_time[pos] <= r.wake_time)
				pos++;
			if (pos == DEPTH) begin
				// Full and nothing later: drop the new request.
				o.lost = 1'b1;
			end else begin
				if (row_live[pos]) begin
					// Push later entries back; a live last entry falls off the end.
					o.lost = row_live[DEPTH-1];
					for (k = DEPTH - 1; k > pos; k--) begin
						row_time[k] = row_time[k-1];
						row_task[k] = row_task[k-1];
						row_live[k] = row_live[k-1];
					end
				end
				row_time[pos] = r.wake_time;
				row_task[pos] = r.task_id & TASK_MASK;
				row_live[pos] = 1'b1;
			end
		end else if (row_live[0] && r.current_time >= row_time[0]) begin
			// Head is due: pop it and advance the rest of the row.
			o.woke       = 1'b1;
			o.woken_task = row_task[0];
			for (k = 1; k < DEPTH; k++) begin
				row_time[k-1] = row_time[k];
				row_task[k-1] = row_task[k];
				row_live[k-1] = row_live[k];
			end
			row_time[DEPTH-1] = '0;
			row_task[DEPTH-1] = '0;
			row_live[DEPTH-1] = 1'b0;
		end
		return o;
	endfunction

	// Offer one request beat after a random gap and hold it until taken. Valid is left high
	// on return so that a back-to-back beat never lowers and raises it in the same step.
	task automatic send_beat(input req_t r);
		int gap;
		gap = idle_en ? int'($urandom_range(0, 9)) : 0;
		if (gap > 0) begin
			@(negedge clk);
			req_valid <= 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
		@(negedge clk);
		req_valid <= 1'b1;
		req       <= r;
		do @(posedge clk); while (req_stall);
		awaited_rsp.push_back(next_wakeup_rsp(r));
	endtask

	// The fields that the operation ignores still carry random bits.
	task automatic insert_beat(input logic [TIME_W-1:0] when, input logic [TASK_W-1:0] id);
		req_t r;
		r.opcode       = OP_INSERT;
		r.wake_time    = when;
		r.task_id      = id;
		r.current_time = $urandom();
		send_beat(r);
	endtask

	task automatic check_beat(input logic [TIME_W-1:0] now);
		req_t r;
		r.opcode       = OP_CHECK;
		r.wake_time    = $urandom();
		r.task_id      = TASK_W'($urandom());
		r.current_time = now;
		send_beat(r);
	endtask

	// Empty head, time extremes, ties, eviction and drop on a full row, then drain.
	task automatic test_directed();
		check_beat('0);			// head inactive: nothing happens
		insert_beat('0, '0);
		check_beat('0);			// due at time zero
		insert_beat('1, '1);
		check_beat(32'hFFFF_FFFE);	// not yet due
		check_beat('1);
		// Fill the row, with two pairs of equal times to exercise age order.
		insert_beat(32'd100, 8'd1);
		insert_beat(32'd50, 8'd2);
		insert_beat(32'd50, 8'd3);
		insert_beat(32'd200, 8'd4);
		insert_beat(32'd300, 8'd5);
		insert_beat(32'd100, 8'd6);
		insert_beat(32'd400, 8'd7);
		insert_beat('1, 8'hFF);
		insert_beat(32'd60, 8'hA5);	// full, earlier time: last entry falls off
		insert_beat('1, 8'h5A);		// full, not earlier than any entry: dropped
		insert_beat(32'd400, 8'h3C);	// full, equal to the last entry: dropped
		check_beat(32'd49);
		check_beat(32'd50);
		repeat (7) check_beat('1);
	endtask

	// Realistic traffic: a running system clock, wake times a little ahead of it, and
	// phases that alternate between filling and draining the row.
	task automatic test_timed_traffic(input int n);
		logic [TIME_W-1:0] sys_now;
		int                fill_pct;
		int                i;
		sys_now  = $urandom_range(0, 32'hF000_0000);
		fill_pct = 80;
		for (i = 0; i < n; i++) begin
			if (i % 40 == 0)
				fill_pct = (fill_pct == 80) ? 35 : 80;
			if (i % 100 == 0)
				idle_en = (i % 300 != 200);
			if ($urandom_range(0, 99) < fill_pct) begin
				// A coarse grid of deltas now and then, so that equal times are common.
				if ($urandom_range(0, 3) == 0)
					insert_beat(sys_now + 8 * $urandom_range(0, 4), TASK_W'($urandom()));
				else
					insert_beat(sys_now + $urandom_range(0, 60), TASK_W'($urandom()));
			end else begin
				sys_now = sys_now + $urandom_range(0, 12);
				check_beat(sys_now);
			end
		end
		idle_en = 1'b1;
	endtask

	// Bursts of inserts over a narrow time window overrun the row; short check runs
	// around the same window pop some of it back out.
	task automatic test_overflow_bursts(input int n);
		logic [TIME_W-1:0] base;
		int                sent;
		int                j;
		int                len;
		sent = 0;
		while (sent < n) begin
			idle_en = ($urandom_range(0, 3) != 0);
			base    = $urandom_range(0, 32'hFFFF_FF00);
			len     = $urandom_range(6, 14);
			for (j = 0; j < len; j++)
				insert_beat(base + $urandom_range(0, 5), TASK_W'($urandom()));
			sent += len;
			len = $urandom_range(2, 10);
			for (j = 0; j < len; j++)
				check_beat(base + $urandom_range(0, 6));
			sent += len;
		end
		idle_en = 1'b1;
	endtask

	// Unshaped beats: every field drawn over its whole range.
	task automatic test_raw_noise(input int n);
		req_t r;
		int   i;
		for (i = 0; i < n; i++) begin
			if (i % 75 == 0)
				idle_en = ~idle_en;
			r.opcode       = 1'($urandom_range(0, 1));
			r.wake_time    = $urandom();
			r.task_id      = TASK_W'($urandom());
			r.current_time = $urandom();
			send_beat(r);
		end
		idle_en = 1'b1;
	endtask

	// Drive the response stall: hold it for the drawn number of cycles, then release
	// until the next response beat is taken.
	always @(negedge clk) begin
		if (rsp_hold > 0) begin
			rsp_stall <= 1'b1;
			rsp_hold = rsp_hold - 1;
		end else begin
			rsp_stall <= 1'b0;
		end
	end

	// Compare each response beat, field by field, with the oldest owed response.
	always @(posedge clk) begin
		rsp_t want;
		if (arst_n && rsp_valid && !rsp_stall) begin
			rsp_hold = idle_en ? int'($urandom_range(0, 9)) : 0;
			if (awaited_rsp.size() == 0) begin
				mismatches++;
				if (mismatches <= MAX_SHOWN)
					$display("[%0t] response beat with none owed: woke=%0b task=%0d lost=%0b",
						$time, rsp.woke, rsp.woken_task, rsp.lost);
			end else begin
				want = awaited_rsp.pop_front();
				if (rsp.woke !== want.woke || rsp.woken_task !== want.woken_task ||
					rsp.lost !== want.lost) begin
					mismatches++;
					if (mismatches <= MAX_SHOWN)
						$display({"[%0t] response mismatch: expected woke=%0b task=%0d ",
							"lost=%0b, got woke=%0b task=%0d lost=%0b"}, $time,
							want.woke, want.woken_task, want.lost,
							rsp.woke, rsp.woken_task, rsp.lost);
				end
			end
		end
	end

	// Watchdog: end the run when neither channel has moved a beat for too long.
	always @(posedge clk) begin
		if (arst_n) begin
			if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall))
				quiet_cycles = 0;
			else
				quiet_cycles = quiet_cycles + 1;
			if (quiet_cycles >= QUIET_LIMIT) begin
				$display("FAILED: results differ");
				$finish;
			end
		end
	end

	initial begin
		// Hold reset, then release it away from the active edge.
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		test_directed();
		test_timed_traffic(900);
		test_overflow_bursts(350);
		test_raw_noise(300);

		@(negedge clk);
		req_valid <= 1'b0;
		// Drain the owed responses, then wait for anything stray.
		while (awaited_rsp.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);

		if (mismatches == 0)
			$display("PASSED: all results match");
		else
			$display("FAILED: results differ");
		$finish;
	end

endmodule
